[sv/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, sideband types and the CORDIC arctangent table for the
// quaternion to Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // Number of CORDIC rotations (8 to 24).
  localparam int unsigned CORDIC_STEPS = 16;

  // Width of the scaled sums, where 1.0 is 2^30.
  localparam int unsigned SUM_W = 34;
  // CORDIC vector datapath, with headroom for the gain and the pre-rotation.
  localparam int unsigned CW = 38;
  // Angle accumulator, where 2^31 is pi.
  localparam int unsigned ANG_W = 34;

  // Integer square root of a 61-bit radicand, one result bit per stage.
  localparam int unsigned RAD_W = 61;
  localparam int unsigned ROOT_W = 31;
  localparam int unsigned ROOT_STEPS = 31;
  localparam int unsigned RW = 62;

  localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'sd1073741824);
  localparam logic signed [15:0] HALF_PI_BAM = 16'sd16384;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);

  // Operands that travel alongside the square root.
  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sp;
    logic                    clamp;
    logic                    neg;
  } side_t;

  // Pitch saturation flags delayed across the CORDIC.
  typedef struct packed {
    logic clamp;
    logic neg;
  } flag_t;

  // atan(2^-i) in units where 2^31 is pi.
  function automatic logic [31:0] atan_lut(input int unsigned idx);
    logic [31:0] val;
    case (idx)
      0:       val = 32'h20000000;
      1:       val = 32'h12E4051E;
      2:       val = 32'h09FB385B;
      3:       val = 32'h051111D4;
      4:       val = 32'h028B0D43;
      5:       val = 32'h0145D7E1;
      6:       val = 32'h00A2F61E;
      7:       val = 32'h00517C55;
      8:       val = 32'h0028BE53;
      9:       val = 32'h00145F2F;
      10:      val = 32'h000A2F98;
      11:      val = 32'h000517CC;
      12:      val = 32'h00028BE6;
      13:      val = 32'h000145F3;
      14:      val = 32'h0000A2FA;
      15:      val = 32'h0000517D;
      16:      val = 32'h000028BE;
      17:      val = 32'h0000145F;
      18:      val = 32'h00000A30;
      19:      val = 32'h00000518;
      20:      val = 32'h0000028C;
      21:      val = 32'h00000146;
      22:      val = 32'h000000A3;
      23:      val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

[sv/q2e_isqrt.sv]
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined integer square root, one result bit per stage, carrying the
// remaining angle operands alongside.
// ----------------------------------------------------------------------------
module q2e_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [q2e_pkg::RAD_W-1:0]     rad_i,
  input  q2e_pkg::side_t                side_i,
  output logic [q2e_pkg::ROOT_W-1:0]    root_o,
  output q2e_pkg::side_t                side_o
);
  import q2e_pkg::*;

  logic [RW-1:0] rem_q  [0:ROOT_STEPS];
  logic [RW-1:0] res_q  [0:ROOT_STEPS];
  side_t         side_q [0:ROOT_STEPS];

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {{(RW-RAD_W){1'b0}}, rad_i};
      res_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  // One trial subtraction per stage, trial bit walking down by two places.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [RW-1:0] TrialBit = RW'(1) << (2 * (ROOT_STEPS - 1 - k));
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_d;
    logic [RW-1:0] res_d;

    always_comb begin
      trial = res_q[k] + TrialBit;
      if (rem_q[k] >= trial) begin
        rem_d = rem_q[k] - trial;
        res_d = (res_q[k] >> 1) + TrialBit;
      end else begin
        rem_d = rem_q[k];
        res_d = res_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        res_q[k+1]  <= res_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign root_o = res_q[ROOT_STEPS][ROOT_W-1:0];
  assign side_o = side_q[ROOT_STEPS];

endmodule

[sv/q2e_cordic.sv]
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined CORDIC in vectoring mode giving the atan2 angle accumulator,
// with a quadrant pre-rotation stage and one rotation per stage.
// ----------------------------------------------------------------------------
module q2e_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [q2e_pkg::SUM_W-1:0]   y_i,
  input  logic signed [q2e_pkg::SUM_W-1:0]   x_i,
  output logic signed [q2e_pkg::ANG_W-1:0]   ang_o
);
  import q2e_pkg::*;

  logic signed [CW-1:0]    x_q   [0:CORDIC_STEPS];
  logic signed [CW-1:0]    y_q   [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] ang_q [0:CORDIC_STEPS];

  logic signed [CW-1:0]    x_ext;
  logic signed [CW-1:0]    y_ext;
  logic signed [CW-1:0]    x0_d;
  logic signed [CW-1:0]    y0_d;
  logic signed [ANG_W-1:0] ang0_d;

  // Fold the left half-plane onto the right by a quarter turn.
  always_comb begin
    x_ext = {{(CW-SUM_W){x_i[SUM_W-1]}}, x_i};
    y_ext = {{(CW-SUM_W){y_i[SUM_W-1]}}, y_i};
    x0_d   = x_ext;
    y0_d   = y_ext;
    ang0_d = '0;
    if (x_ext < 0) begin
      if (y_ext >= 0) begin
        x0_d   = y_ext;
        y0_d   = -x_ext;
        ang0_d = QUARTER_TURN;
      end else begin
        x0_d   = -y_ext;
        y0_d   = x_ext;
        ang0_d = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= x0_d;
      y_q[0]   <= y0_d;
      ang_q[0] <= ang0_d;
    end
  end

  // Rotation stages: drive y towards zero, accumulating the angle.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] StepAng = ANG_W'(atan_lut(i));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1]   <= x_q[i] + dx;
          y_q[i+1]   <= y_q[i] - dy;
          ang_q[i+1] <= ang_q[i] + StepAng;
        end else begin
          x_q[i+1]   <= x_q[i] - dx;
          y_q[i+1]   <= y_q[i] + dy;
          ang_q[i+1] <= ang_q[i] - StepAng;
        end
      end
    end
  end

  assign ang_o = ang_q[CORDIC_STEPS];

endmodule

[sv/quaternion_to_euler_core.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_core
// Orientation quaternion in signed Q1.15 to roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one quaternion (w, x, y, z) per transaction and
//   the output channel returns roll, pitch and yaw, where 32768 is pi, plus
//   a flag set when the sine of pitch reached magnitude one and pitch was
//   held at plus or minus half pi.
//   Throughput is one transaction per cycle while the output does not stall.
//   The pipeline has one product stage, one sum stage, 32 stages of the
//   bit-per-stage square root for the pitch cosine, CORDIC_STEPS + 1 CORDIC
//   stages and the output register. The square root pipeline sets most of
//   the latency.
//   The whole pipeline advances together: when the receiver holds ready low
//   while a result waits, every stage holds, in_ready_o falls, and nothing
//   is lost or repeated. Bubbles travel as cleared valid bits.
//   Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o,
  output logic               pitch_clamped_o
);
  import q2e_pkg::*;

  localparam int unsigned Depth = 2 + (ROOT_STEPS + 1) + (CORDIC_STEPS + 1);

  logic en;
  logic vld_q [0:Depth-1];
  logic out_valid_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // Valid bits move with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < Depth; k++) vld_q[k] <= vld_q[k-1];
      out_valid_q <= vld_q[Depth-1];
    end
  end

  // Stage one: the nine products.
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= quat_w_i * quat_x_i;
      yz_q <= quat_y_i * quat_z_i;
      xx_q <= quat_x_i * quat_x_i;
      yy_q <= quat_y_i * quat_y_i;
      wy_q <= quat_w_i * quat_y_i;
      zx_q <= quat_z_i * quat_x_i;
      wz_q <= quat_w_i * quat_z_i;
      xy_q <= quat_x_i * quat_y_i;
      zz_q <= quat_z_i * quat_z_i;
    end
  end

  // Stage two: doubled sums and the pitch saturation test.
  function automatic logic signed [SUM_W-1:0] sx(input logic signed [31:0] v);
    return {{(SUM_W-32){v[31]}}, v};
  endfunction

  side_t side_d, side_q;

  always_comb begin
    side_d.sr    = (sx(wx_q) + sx(yz_q)) <<< 1;
    side_d.cr    = ONE_Q30 - ((sx(xx_q) + sx(yy_q)) <<< 1);
    side_d.sp    = (sx(wy_q) - sx(zx_q)) <<< 1;
    side_d.sy    = (sx(wz_q) + sx(xy_q)) <<< 1;
    side_d.cy    = ONE_Q30 - ((sx(yy_q) + sx(zz_q)) <<< 1);
    side_d.clamp = (side_d.sp >= ONE_Q30) || (side_d.sp <= -ONE_Q30);
    side_d.neg   = side_d.sp[SUM_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) side_q <= side_d;
  end

  // Radicand 2^60 - s^2 for the pitch cosine; unused when saturated.
  logic signed [ROOT_W-1:0] sp_short;
  logic signed [RW-1:0]     sp_sq;
  logic [RW-1:0]            rad_full;
  logic [RAD_W-1:0]         rad;

  always_comb begin
    sp_short = side_q.clamp ? '0 : side_q.sp[ROOT_W-1:0];
    sp_sq    = sp_short * sp_short;
    rad_full = (RW'(1) << (RAD_W - 1)) - RW'(sp_sq);
    rad      = rad_full[RAD_W-1:0];
  end

  logic [ROOT_W-1:0] root;
  side_t             side_r;

  q2e_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad),
    .side_i (side_q),
    .root_o (root),
    .side_o (side_r)
  );

  // Three angle units in step.
  logic signed [ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
  logic signed [SUM_W-1:0] cos_p;

  assign cos_p = {{(SUM_W-ROOT_W){1'b0}}, root};

  q2e_cordic u_roll (
    .clk_i (clk_i), .en_i (en),
    .y_i (side_r.sr), .x_i (side_r.cr), .ang_o (roll_ang)
  );

  q2e_cordic u_pitch (
    .clk_i (clk_i), .en_i (en),
    .y_i (side_r.sp), .x_i (cos_p), .ang_o (pitch_ang)
  );

  q2e_cordic u_yaw (
    .clk_i (clk_i), .en_i (en),
    .y_i (side_r.sy), .x_i (side_r.cy), .ang_o (yaw_ang)
  );

  // Saturation flags delayed to match the angle units.
  flag_t flag_q [0:CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_q[0] <= '{clamp: side_r.clamp, neg: side_r.neg};
      for (int k = 1; k <= CORDIC_STEPS; k++) flag_q[k] <= flag_q[k-1];
    end
  end

  // Round the accumulators to 16 bits and select the saturated pitch.
  function automatic logic signed [15:0] rnd(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] t;
    t = (a + ANG_W'(32768)) >>> 16;
    return t[15:0];
  endfunction

  logic signed [15:0] pitch_d;

  always_comb begin
    if (flag_q[CORDIC_STEPS].clamp) begin
      pitch_d = flag_q[CORDIC_STEPS].neg ? -HALF_PI_BAM : HALF_PI_BAM;
    end else begin
      pitch_d = rnd(pitch_ang);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_angle_o    <= rnd(roll_ang);
      pitch_angle_o   <= pitch_d;
      yaw_angle_o     <= rnd(yaw_ang);
      pitch_clamped_o <= flag_q[CORDIC_STEPS].clamp;
    end
  end

`ifndef SYNTH
  // A saturated result always carries exactly plus or minus half pi.
  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pitch_clamped_o |->
      (pitch_angle_o == HALF_PI_BAM) || (pitch_angle_o == -HALF_PI_BAM))
    else $error("saturated pitch is not half pi");

  // Pitch never leaves the half-pi range.
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_angle_o <= HALF_PI_BAM) && (pitch_angle_o >= -HALF_PI_BAM))
    else $error("pitch outside half pi");

  // The saturation flag follows the magnitude test made at the sum stage.
  a_clamp_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[0] |=> side_q.clamp ==
      ((side_q.sp >= ONE_Q30) || (side_q.sp <= -ONE_Q30)))
    else $error("saturation flag disagrees with sine");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Quaternion to Euler angle converter testbench
// Drives quaternions through the valid/ready input channel, predicts roll,
// pitch and yaw with a bit-exact CORDIC and square-root model, and checks
// every result transaction in order under random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import q2e_pkg::*;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  // Scoreboard: predicts angles for each accepted quaternion and checks them.
  class euler_scoreboard;
    euler_t angle_q[$];
    int     mismatches;
    int     checked;

    function automatic longint floor_shr(longint v, int k);
      return v >>> k;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function automatic logic signed [15:0] vector_angle(longint yv, longint xv);
      longint ang;
      longint t;
      longint dx;
      longint dy;
      ang = 0;
      // Pre-rotate the left half-plane by a quarter turn.
      if (xv < 0) begin
        if (yv >= 0) begin
          t = xv; xv = yv; yv = -t; ang = 64'sh40000000;
        end else begin
          t = xv; xv = -yv; yv = t; ang = -64'sh40000000;
        end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        dx = floor_shr(yv, i);
        dy = floor_shr(xv, i);
        if (yv >= 0) begin
          xv += dx; yv -= dy; ang += longint'(atan_lut(i));
        end else begin
          xv -= dx; yv += dy; ang -= longint'(atan_lut(i));
        end
      end
      return 16'(floor_shr(ang + 32768, 16));
    endfunction

    function automatic void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                            logic signed [15:0] qy, logic signed [15:0] qz);
      longint w, x, y, z, sr, cr, sp, sy, cy, one;
      euler_t e;
      w = qw; x = qx; y = qy; z = qz;
      one = 64'sd1 << 30;
      sr = 2 * (w * x + y * z);
      cr = one - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = one - 2 * (y * y + z * z);
      e.clamped = 1'b0;
      if (sp >= one) begin
        e.pitch = 16'sd16384; e.clamped = 1'b1;
      end else if (sp <= -one) begin
        e.pitch = -16'sd16384; e.clamped = 1'b1;
      end else begin
        e.pitch = vector_angle(sp, longint'(root64((64'd1 << 60) - longint'(sp * sp))));
      end
      e.roll = vector_angle(sr, cr);
      e.yaw = vector_angle(sy, cy);
      angle_q.insert(angle_q.size(), e);
    endfunction

    function automatic void check_angles(euler_t got);
      euler_t exp_e;
      checked++;
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: roll %0d", got.roll);
        return;
      end
      exp_e = angle_q.pop_front();
      if (got.roll !== exp_e.roll || got.pitch !== exp_e.pitch || got.yaw !== exp_e.yaw ||
          got.clamped !== exp_e.clamped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch #%0d: expected r/p/y/c %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   checked, exp_e.roll, exp_e.pitch, exp_e.yaw, exp_e.clamped,
                   got.roll, got.pitch, got.yaw, got.clamped);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] quat_w_i = '0;
  logic signed [15:0] quat_x_i = '0;
  logic signed [15:0] quat_y_i = '0;
  logic signed [15:0] quat_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] roll_angle_o;
  logic signed [15:0] pitch_angle_o;
  logic signed [15:0] yaw_angle_o;
  logic               pitch_clamped_o;

  euler_scoreboard scb = new();
  int  sent;
  bit  long_hold;
  bit  stim_done;
  int  n_clamped;

  quaternion_to_euler_core DUT (.*);

  always #4 clk_i = ~clk_i;

  // Sample both channels at the rising edge.
  always @(posedge clk_i) begin
    euler_t got;
    if (rst_ni && in_valid_i && in_ready_o) begin
      scb.note_quaternion(quat_w_i, quat_x_i, quat_y_i, quat_z_i);
      sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.roll = roll_angle_o; got.pitch = pitch_angle_o;
      got.yaw = yaw_angle_o; got.clamped = pitch_clamped_o;
      if (pitch_clamped_o) n_clamped++;
      scb.check_angles(got);
    end
  end

  // Receiver: own stall pattern, plus one long hold-off.
  initial begin
    int mode;
    forever begin
      @(negedge clk_i);
      if (long_hold) out_ready_i <= 1'b0;
      else begin
        mode = (sent / 200) % 3;
        if (mode == 0) out_ready_i <= 1'b1;
        else if (mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
        else out_ready_i <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  // Offer one quaternion and hold it until accepted.
  task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    in_valid_i <= 1'b1;
    quat_w_i <= w; quat_x_i <= x; quat_y_i <= y; quat_z_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    idle_cycles(1);
    while (scb.angle_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int burst;
    int s;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity, extremes, gimbal lock both ways, pi wrap, zeros.
    send_quat(16'sh7FFF, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
    send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_quat(16'sh5A82, 0, 16'sh5A82, 0);
    send_quat(16'sh5A82, 0, -16'sh5A82, 0);
    send_quat(16'sh4000, 16'sh4000, 16'sh4000, -16'sh4000);
    send_quat(16'sh4000, -16'sh4000, -16'sh4000, 16'sh4000);
    send_quat(0, 16'sh7FFF, 0, 0);
    send_quat(0, 0, 0, 16'sh7FFF);
    send_quat(0, 0, 16'sh7FFF, 0);
    send_quat(0, -16'sh8000, 0, 0);
    send_quat(0, 0, 0, -16'sh8000);
    send_quat(16'sh7FFF, 16'sh0001, 16'sh0000, 16'sh0000);
    send_quat(16'sh7FFF, -16'sh0001, 16'sh0000, -16'sh0001);
    send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    send_quat(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        long_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        long_hold = 1'b0;
      end
      repeat (120) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    join
    drain();

    // Random bursts with random gaps; unit-norm-ish and raw values mixed.
    while (sent < 1300) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        s = $urandom_range(0, 3);
        if (s == 0) send_quat(16'($urandom_range(0, 23170)), 16'($urandom_range(0, 23170)),
                              16'($urandom_range(0, 23170)), -16'($urandom_range(0, 23170)));
        else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 20));
      if ($urandom_range(0, 30) == 0) drain();
    end
    drain();
    repeat (CORDIC_STEPS + 60) @(negedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    $display("Covered %0d quaternions (%0d with pitch at half pi), extremes and long stalls.",
             sent, n_clamped);
    if (scb.mismatches == 0 && scb.angle_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", scb.mismatches, scb.angle_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", scb.angle_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
